### design/projectile_pool_engine_defines.svh
// Assertion helpers shared by the projectile pool design.
`ifndef PROJECTILE_POOL_ENGINE_DEFINES_SVH
`define PROJECTILE_POOL_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ppe_pkg.sv
`default_nettype none
package ppe_pkg;

   // Action codes of a request.
   localparam logic [2:0] ACT_SPAWN   = 3'd0;
   localparam logic [2:0] ACT_TICK    = 3'd1;
   localparam logic [2:0] ACT_COLLIDE = 3'd2;
   localparam logic [2:0] ACT_KILL    = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_MIN_X = 2'd0;
   localparam logic [1:0] CSR_MIN_Y = 2'd1;
   localparam logic [1:0] CSR_MAX_X = 2'd2;
   localparam logic [1:0] CSR_MAX_Y = 2'd3;

   // Reset values of the culling bounds.
   localparam logic signed [15:0] MIN_X_RESET = -16'sd512;
   localparam logic signed [15:0] MIN_Y_RESET = -16'sd512;
   localparam logic signed [15:0] MAX_X_RESET = 16'sd5632;
   localparam logic signed [15:0] MAX_Y_RESET = 16'sd4352;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic [23:0]        life_span;
      logic [63:0]        hit_mask;
      logic [15:0]        delta_time;
      logic [14:0]        probe_radius;
      logic [63:0]        target_category;
      logic [7:0]         slot_index;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] result_slot;
      logic [8:0] live_count;
   } rsp_type;

   // One pool entry as stored in the entry memory.
   typedef struct packed {
      logic               live;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic [23:0]        life;
      logic [23:0]        age;
      logic [63:0]        mask;
   } entry_type;

endpackage
`default_nettype wire

### design/projectile_pool_engine.sv
// Requests use the entry memory and one shared 18x18 multiplier: spawn reads entries up to
// the first free one, tick updates every live entry with two multiplies, collide squares the
// probe radius and then tests the live entries that pass the category filter until a hit,
// kill clears its slot if it is live, and clear writes every entry. The result is loaded in
// the done state once the output register is free; the next request is taken in idle.
// Reset is synchronous; afterwards a clearing pass writes every entry.
`default_nettype none
`include "projectile_pool_engine_defines.svh"
module projectile_pool_engine #(
   parameter int POOL_DEPTH = 256
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  ppe_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output ppe_pkg::rsp_type    rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [1:0]          csr_index,
   input  wire  signed [15:0]  csr_data
);
   import ppe_pkg::*;

   localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_RADIUS = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_EVAL   = 3'd4;
   localparam logic [2:0] ST_MUL2   = 3'd5;
   localparam logic [2:0] ST_FIN2   = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 boot_ff, boot_in;
   req_type              req_ff, req_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        slot_ff, slot_in;
   logic signed [35:0]   prod_ff, prod_in;
   logic [33:0]          sq_ff, sq_in;
   logic [29:0]          r2_ff, r2_in;
   logic signed [15:0]   nx_ff, nx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic signed [15:0]   min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   entry_type            mem [POOL_DEPTH];
   entry_type            rd_ff;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   entry_type            wr_data;

   // Shared multiplier.
   logic signed [17:0]   mul_a, mul_b;
   logic signed [35:0]   mul_p;

   // Per-entry arithmetic.
   logic signed [17:0]   pos_sum;
   logic signed [15:0]   pos_sat;
   logic [24:0]          age_sum;
   logic [23:0]          age_sat;
   logic signed [16:0]   dx, dy;
   logic [34:0]          dist2;
   logic                 pass_filter;
   logic                 cull;
   logic                 accept;

   assign mul_p = mul_a * mul_b;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign dx = 17'(rd_ff.x) - 17'(req_ff.pos_x);
   assign dy = 17'(rd_ff.y) - 17'(req_ff.pos_y);
   assign dist2 = 35'(sq_ff) + 35'(prod_ff[33:0]);
   assign pass_filter = (req_ff.target_category == 64'd0) ||
                        ((rd_ff.mask & req_ff.target_category) != 64'd0);

   // Position step: floor of the product over 2^16, then saturate.
   always_comb begin
      if (state_ff == ST_MUL2) begin
         pos_sum = 18'(rd_ff.x) + 18'(prod_ff >>> 16);
      end else begin
         pos_sum = 18'(rd_ff.y) + 18'(prod_ff >>> 16);
      end
      if (pos_sum > 18'sd32767) begin
         pos_sat = 16'sh7FFF;
      end else if (pos_sum < -18'sd32768) begin
         pos_sat = -16'sh8000;
      end else begin
         pos_sat = pos_sum[15:0];
      end
   end

   // Age update and culling decision for the tick write-back.
   always_comb begin
      age_sum = {1'b0, rd_ff.age} + 25'(req_ff.delta_time);
      age_sat = age_sum[24] ? 24'hFF_FFFF : age_sum[23:0];
      cull = ((rd_ff.life != 24'd0) && (age_sat >= rd_ff.life)) ||
             (nx_ff < min_x_ff) || (nx_ff > max_x_ff) ||
             (pos_sat < min_y_ff) || (pos_sat > max_y_ff);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      cnt_in       = cnt_ff;
      boot_in      = boot_ff;
      req_in       = req_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      prod_in      = prod_ff;
      sq_in        = sq_ff;
      r2_in        = r2_ff;
      nx_in        = nx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_ff;
      mul_a        = 18'(rd_ff.vx);
      mul_b        = 18'(req_ff.delta_time);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               idx_in   = '0;
               cnt_in   = '0;
               found_in = 1'b0;
               slot_in  = '0;
               case (req_data.action)
                  ACT_SPAWN:   state_in = ST_READ;
                  ACT_TICK:    state_in = ST_READ;
                  ACT_COLLIDE: state_in = ST_RADIUS;
                  ACT_KILL: begin
                     idx_in = IW'(req_data.slot_index);
                     if (32'(req_data.slot_index) < POOL_DEPTH) begin
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  ACT_CLEAR:   state_in = ST_CLEAR;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            if (idx_ff == LAST_IDX) begin
               total_in = '0;
               boot_in  = 1'b0;
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RADIUS: begin
            mul_a    = 18'(req_ff.probe_radius);
            mul_b    = 18'(req_ff.probe_radius);
            r2_in    = mul_p[29:0];
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            case (req_ff.action)
               ACT_SPAWN: begin
                  if (!rd_ff.live) begin
                     wr_en         = 1'b1;
                     wr_data.live  = 1'b1;
                     wr_data.x     = req_ff.pos_x;
                     wr_data.y     = req_ff.pos_y;
                     wr_data.vx    = req_ff.vel_x;
                     wr_data.vy    = req_ff.vel_y;
                     wr_data.life  = req_ff.life_span;
                     wr_data.age   = '0;
                     wr_data.mask  = req_ff.hit_mask;
                     total_in      = total_ff + 1'b1;
                     found_in      = 1'b1;
                     slot_in       = idx_ff;
                     state_in      = ST_DONE;
                  end else if (idx_ff == LAST_IDX) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end
               ACT_TICK: begin
                  if (rd_ff.live) begin
                     prod_in  = mul_p;
                     state_in = ST_MUL2;
                  end else if (idx_ff == LAST_IDX) begin
                     total_in = cnt_ff;
                     state_in = ST_DONE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end
               ACT_COLLIDE: begin
                  mul_a = 18'(dx);
                  mul_b = 18'(dx);
                  if (rd_ff.live && pass_filter) begin
                     prod_in  = mul_p;
                     state_in = ST_MUL2;
                  end else if (idx_ff == LAST_IDX) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end
               default: begin
                  // Kill of one slot.
                  if (rd_ff.live) begin
                     wr_en        = 1'b1;
                     wr_data.live = 1'b0;
                     if (total_ff != '0) begin
                        total_in = total_ff - 1'b1;
                     end
                  end
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_MUL2: begin
            if (req_ff.action == ACT_TICK) begin
               nx_in = pos_sat;
               mul_a = 18'(rd_ff.vy);
            end else begin
               sq_in = prod_ff[33:0];
               mul_a = 18'(dy);
               mul_b = 18'(dy);
            end
            prod_in  = mul_p;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            state_in = ST_READ;
            if (req_ff.action == ACT_TICK) begin
               wr_en        = 1'b1;
               wr_data.live = !cull;
               wr_data.x    = nx_ff;
               wr_data.y    = pos_sat;
               wr_data.age  = age_sat;
               if (!cull) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (idx_ff == LAST_IDX) begin
                  total_in = cnt_in;
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (dist2 <= 35'(r2_ff)) begin
               found_in = 1'b1;
               slot_in  = idx_ff;
               state_in = ST_DONE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = found_ff;
               rsp_in.result_slot = 8'(slot_ff);
               rsp_in.live_count  = 9'(total_ff);
               state_in           = ST_IDLE;
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         total_ff     <= '0;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      req_ff   <= req_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
      prod_ff  <= prod_in;
      sq_ff    <= sq_in;
      r2_ff    <= r2_in;
      nx_ff    <= nx_in;
      rsp_ff   <= rsp_in;
   end

   // Culling bounds.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= MIN_X_RESET;
         min_y_ff <= MIN_Y_RESET;
         max_x_ff <= MAX_X_RESET;
         max_y_ff <= MAX_Y_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_X: min_x_ff <= csr_data;
            CSR_MIN_Y: min_y_ff <= csr_data;
            CSR_MAX_X: max_x_ff <= csr_data;
            CSR_MAX_Y: max_y_ff <= csr_data;
            default:   min_x_ff <= min_x_ff;
         endcase
      end
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_ff];
   end

   `PPE_ASSERT_NOW(a_total_bound, clock, reset, 1'b1, total_ff <= CW'(POOL_DEPTH),
      "live total exceeds pool depth")
   `PPE_ASSERT_NOW(a_slot_zero, clock, reset, rsp_valid_ff && !rsp_ff.found,
      rsp_ff.result_slot == 8'd0, "result slot nonzero without a find")
   `PPE_ASSERT_NEXT(a_busy, clock, reset, accept, state_ff != ST_IDLE,
      "accepted request did not start work")
   `PPE_ASSERT_NOW(a_write_state, clock, reset, wr_en,
      state_ff == ST_EVAL || state_ff == ST_FIN2 || state_ff == ST_CLEAR,
      "entry memory written outside a write state")

endmodule
`default_nettype wire
